// ===== hw/rtl/rxr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rxr_pkg;

   localparam int unsigned OperandWidth = 16;
   localparam int unsigned ValueWidth   = 15;
   localparam int unsigned StateWidth   = 32;
   localparam int unsigned ShiftA       = 13;
   localparam int unsigned ShiftB       = 17;
   localparam int unsigned ShiftC       = 5;
   localparam int unsigned DataBytes    = (ValueWidth + 7) / 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DIVIDE,
      ST_FINISH
   } ctrl_state_type;

   // Command to the generator: reseed or advance, plus the mode to record.
   typedef struct packed {
      logic                  load;
      logic                  advance;
      logic                  mode;
      logic [StateWidth-1:0] seed;
   } gen_cmd_type;

   // Status of the remainder unit back to the controller.
   typedef struct packed {
      logic                  done;
      logic [ValueWidth-1:0] remainder;
   } div_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rxr_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rxr_generator
   import rxr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gen_cmd_type           cmd,
   output logic [StateWidth-1:0]      next_value,
   output logic                       mode
);

   logic [StateWidth-1:0] state_ff, state_in;
   logic                  mode_ff, mode_in;
   logic [StateWidth-1:0] x1, x2;

   // One xorshift step: three shift-xor layers of plain wiring.
   always_comb begin
      x1         = state_ff ^ (state_ff << ShiftA);
      x2         = x1 ^ (x1 >> ShiftB);
      next_value = x2 ^ (x2 << ShiftC);
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      if (cmd.load) begin
         mode_in  = cmd.mode;
         // a zero seed would lock the generator at zero
         state_in = (cmd.seed == '0) ? StateWidth'(1) : cmd.seed;
      end else if (cmd.advance) begin
         state_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateWidth'(1);
         mode_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   assign mode = mode_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rxr_remainder.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rxr_remainder
   import rxr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [StateWidth-1:0] dividend,
   input  wire logic [ValueWidth-1:0] divisor,
   output div_status_type             status
);

   localparam int unsigned CountWidth = $clog2(StateWidth);

   logic [StateWidth-1:0] shift_ff, shift_in;
   logic [ValueWidth-1:0] rem_ff, rem_in;
   logic [ValueWidth-1:0] dsr_ff, dsr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ValueWidth:0]   trial;

   // Restoring remainder, one dividend bit per cycle, MSB first.
   always_comb begin
      trial    = {rem_ff, shift_ff[StateWidth-1]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[StateWidth-2:0], 1'b0};
         // subtract when the trial value covers the divisor
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = ValueWidth'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = ValueWidth'(trial);
         end
         count_in = count_ff + CountWidth'(1);
         if (count_ff == CountWidth'(StateWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ranged_xorshift_random_opcode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Random-instruction unit with a ranged xorshift generator.
// Request channel (req_*): one signed 16-bit operand per request in tdata.
//   Positive: advance the 32-bit generator and return state mod operand + 1.
//   Zero: enter random mode and reseed from the csr seed register.
//   Negative: enter predictable mode and reseed from the operand's magnitude.
// Response channel (rsp_*): tdata carries the 15-bit value (0 after a reseed),
//   tuser the mode after the request (1 predictable, 0 random).
// Configuration: csr_write_enable/csr_write_data write the seed; write only
//   while no request is in flight.
// Sequence: a positive operand passes from acceptance to a valid response
//   through one generator step, the bit-serial remainder unit, a capture of
//   the remainder plus one and the output load; a reseed goes straight to the load.
// One request is in flight at a time, and the sequencer returns to idle as the
//   response loads.
// The next request is accepted while the previous response still waits in the
//   output register; a stalled receiver holds the response, and a finished
//   result waits until that register frees up.
// Reset: generator state 1, random mode, seed 0, no response pending.
module ranged_xorshift_random_opcode
   import rxr_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [OperandWidth-1:0]   req_tdata,   // [15:0] operand
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [DataBytes*8-1:0]         rsp_tdata,   // [14:0] result_value
   output logic [0:0]                     rsp_tuser,   // [0] predictable
   input  wire logic                      csr_write_enable,
   input  wire logic [StateWidth-1:0]     csr_write_data
);

   ctrl_state_type        state_ff, state_in;
   logic [ValueWidth-1:0] divisor_ff, divisor_in;
   logic [ValueWidth-1:0] value_ff, value_in;
   logic [ValueWidth-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_mode_ff, rsp_mode_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [StateWidth-1:0] seed_ff;
   gen_cmd_type           gen_cmd;
   logic [StateWidth-1:0] gen_next;
   logic                  gen_mode;
   logic                  div_start;
   div_status_type        div_status;
   logic                  req_accept;
   logic                  out_free;
   logic                  out_load;
   logic                  op_zero;
   logic                  op_negative;
   logic [OperandWidth-1:0] magnitude;

   assign req_accept  = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign op_zero     = (req_tdata == '0);
   assign op_negative = req_tdata[OperandWidth-1];
   assign magnitude   = OperandWidth'(-req_tdata);

   rxr_generator u_generator (
      .clock      (clock),
      .reset      (reset),
      .cmd        (gen_cmd),
      .next_value (gen_next),
      .mode       (gen_mode)
   );

   rxr_remainder u_remainder (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (gen_next),
      .divisor  (divisor_ff),
      .status   (div_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (op_zero || op_negative) ? ST_FINISH : ST_STEP;
            end
         end
         ST_STEP: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready      = 1'b0;
      gen_cmd.load    = 1'b0;
      gen_cmd.advance = 1'b0;
      gen_cmd.mode    = 1'b0;
      gen_cmd.seed    = seed_ff;
      div_start       = 1'b0;
      out_load        = 1'b0;
      divisor_in      = divisor_ff;
      value_in        = value_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_accept) begin
               divisor_in = ValueWidth'(req_tdata);
               value_in   = '0;
               if (op_zero) begin
                  gen_cmd.load = 1'b1;
               end else if (op_negative) begin
                  gen_cmd.load = 1'b1;
                  gen_cmd.mode = 1'b1;
                  gen_cmd.seed = StateWidth'(magnitude);
               end
            end
         end
         ST_STEP: begin
            // advance and hand the new state to the remainder unit together
            gen_cmd.advance = 1'b1;
            div_start       = 1'b1;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               value_in = div_status.remainder + ValueWidth'(1);
            end
         end
         ST_FINISH: begin
            out_load = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_mode_in  = rsp_mode_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = value_ff;
         rsp_mode_in  = gen_mode;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            seed_ff <= csr_write_data;
         end
      end
      divisor_ff   <= divisor_in;
      value_ff     <= value_in;
      rsp_value_ff <= rsp_value_in;
      rsp_mode_ff  <= rsp_mode_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = (DataBytes*8)'(rsp_value_ff);
   assign rsp_tuser  = rsp_mode_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rxr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rxr_checker
   import rxr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic                    req_tready,
   input  wire logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire logic [DataBytes*8-1:0]  rsp_tdata,
   input  wire logic [0:0]              rsp_tuser
);

   // no response survives reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // only one request in flight
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // value never exceeds 15 bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[DataBytes*8-1])
      else $error("response padding bit set");

endmodule

bind ranged_xorshift_random_opcode rxr_checker u_rxr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== tb/sv/ranged_xorshift_random_opcode_tb.sv =====
`timescale 1ns / 1ps

module ranged_xorshift_random_opcode_tb;
   import rxr_pkg::*;

   localparam int CycleLimit    = 400000;
   localparam int HoldOffCycles = 400;
   localparam int DrainCycles   = 40;
   localparam int PhaseItems    = 72;

   typedef struct {
      logic [ValueWidth-1:0] value;
      logic                  predictable;
   } draw_type;

   // Tracks generator state, mode and seed register; holds pending draws.
   class random_opcode_model;
      logic [StateWidth-1:0] gen_state;
      logic                  mode;
      logic [StateWidth-1:0] seed_reg;
      draw_type              expected_draws[$];
      int                    mismatches;

      function new();
         gen_state  = 32'd1;
         mode       = 1'b0;
         seed_reg   = '0;
         mismatches = 0;
      endfunction

      function void reseed(logic [StateWidth-1:0] s);
         gen_state = (s == '0) ? 32'd1 : s;
      endfunction

      function void take_operand(logic [OperandWidth-1:0] op);
         draw_type              d;
         logic [StateWidth-1:0] x;
         logic [StateWidth-1:0] sum;
         d.value = '0;
         if (op == '0) begin
            mode = 1'b0;
            reseed(seed_reg);
         end else if (op[OperandWidth-1]) begin
            mode = 1'b1;
            // 16-bit negation, so the most negative operand gives 32768
            reseed(32'h10000 - {16'd0, op});
         end else begin
            x = gen_state;
            x = x ^ (x << ShiftA);
            x = x ^ (x >> ShiftB);
            x = x ^ (x << ShiftC);
            gen_state = x;
            sum = (x % {16'd0, op}) + 32'd1;
            d.value = sum[ValueWidth-1:0];
         end
         d.predictable = mode;
         expected_draws.push_back(d);
      endfunction

      function void report(string what, int want, int got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      endfunction

      function void check_draw(logic [ValueWidth-1:0] value, logic predictable);
         draw_type want;
         if (expected_draws.size() == 0) begin
            report("unexpected response, value", -1, value);
            return;
         end
         want = expected_draws.pop_front();
         if (value !== want.value)
            report("result_value", want.value, value);
         if (predictable !== want.predictable)
            report("predictable", want.predictable, predictable);
      endfunction

      function int pending();
         return expected_draws.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [OperandWidth-1:0] req_tdata;     // [15:0] operand
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [DataBytes*8-1:0]  rsp_tdata;     // [14:0] result_value
   logic [0:0]              rsp_tuser;     // [0] predictable
   logic                    csr_write_enable;
   logic [StateWidth-1:0]   csr_write_data;

   random_opcode_model model = new();

   bit req_idle;
   bit rsp_idle;
   bit hold_rsp;
   int cycle_count;

   ranged_xorshift_random_opcode i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: random backpressure while rsp_idle is set, plus a long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            for (int k = 0; k < HoldOffCycles; k++) begin
               rsp_tready <= 1'b0;
               @(negedge clock);
            end
         end else begin
            rsp_tready <= !(rsp_idle && $urandom_range(99) < 31);
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         model.check_draw(rsp_tdata[ValueWidth-1:0], rsp_tuser[0]);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_operand(input logic [OperandWidth-1:0] op);
      while (req_idle && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= op;
      do @(posedge clock); while (!req_tready);
      model.take_operand(op);
      @(negedge clock);
   endtask

   // Drop valid and hold until every pending response is back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (model.pending() != 0)
         @(negedge clock);
   endtask

   task automatic write_seed(input logic [StateWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      model.seed_reg = value;
      @(negedge clock);
   endtask

   function automatic logic [OperandWidth-1:0] pick_operand();
      int sel;
      sel = $urandom_range(99);
      if (sel < 10)
         return '0;
      else if (sel < 13)
         return 16'h8000;
      else if (sel < 15)
         return 16'hFFFF;
      else if (sel < 25)
         return 16'(32'h10000 - $urandom_range(32768, 1));
      else if (sel < 45)
         return 16'($urandom_range(16, 1));
      else if (sel < 48)
         return 16'h7FFF;
      else
         return 16'($urandom_range(32767, 1));
   endfunction

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++)
         send_operand(pick_operand());
   endtask

   initial begin
      logic [OperandWidth-1:0] directed[$];
      directed = '{16'd1, 16'h7FFF, 16'h4000, 16'd3, 16'd0, 16'd5, 16'hFFFF, 16'd100,
                   16'h8000, 16'h7FFF, 16'd7, 16'hCFC7, 16'd1000, 16'h0001, 16'd0,
                   16'h5555, 16'h2AAA, 16'd255, 16'h8001, 16'd2};
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_idle         = 1'b1;
      rsp_idle         = 1'b1;
      hold_rsp         = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Seed register still at reset: a zero operand must load one.
      foreach (directed[i])
         send_operand(directed[i]);
      wait_idle();

      write_seed(32'hFFFF_FFFF);
      hold_rsp = 1'b1;
      run_random(PhaseItems);
      wait_idle();

      write_seed(32'd0);
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      run_random(PhaseItems);
      wait_idle();

      write_seed(32'd1);
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      run_random(PhaseItems);
      wait_idle();

      write_seed($urandom());
      hold_rsp = 1'b1;
      run_random(PhaseItems);
      wait_idle();

      write_seed(32'h8000_0000);
      run_random(PhaseItems);
      wait_idle();

      repeat (DrainCycles) @(negedge clock);
      if (model.mismatches == 0 && model.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/rxr_pkg.sv
hw/rtl/rxr_generator.sv
hw/rtl/rxr_remainder.sv
hw/rtl/ranged_xorshift_random_opcode.sv
hw/rtl/rxr_checker.sv
tb/sv/ranged_xorshift_random_opcode_tb.sv
